// ===== hdl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg - shared constants for the farthest point selector
// Store depth, coordinate and distance widths, and the configuration reset.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int COORD_BITS     = 16;
  localparam int IDX_W          = $clog2(MAX_CANDIDATES);
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int SQ_W           = 2 * COORD_BITS + 1;
  localparam int XY_W           = 2 * COORD_BITS;
  localparam int CFG_W          = 7;
  localparam int OUT_IDX_W      = 6;
  localparam int RESULT_CAP     = 64;
  localparam int MAX_POINTS_RST = 16;

endpackage

// ===== hdl/farthest_point_selector.sv =====
// ----------------------------------------------------------------------------
// farthest_point_selector - farthest point sampling over a stored point set
// Loads 2-D points up to a set_last item, then emits either all of them or
// cfg-limited picks chosen by farthest point selection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one point per transfer, one cycle
//   each while loading. in_stall stays high from the set_last transfer until
//   the last result of that set has entered the output register.
//   Output channel (out_valid / out_stall): one registered result item per
//   emitted point; out_result_last marks the last one of a set.
//   cfg_we / cfg_wdata write max_points (reset 16). The user must write it
//   only while idle; the block does not enforce this.
// Sequencing:
//   Set of n points with n <= limit: each result takes an ST_EMIT_RD read
//   and an ST_EMIT_WR write. Otherwise each pick takes one sweep over the
//   point memory: n issued reads, a 4-stage distance pipeline and ST_PICK;
//   the point and nearest-distance memories each have a single read port.
// Reset clears the set counters, the picked mask and the output valid flag;
// point memories are not cleared. When the receiver stalls, the result is
// held in the output register and the next pick or emit waits until it is free.
// ----------------------------------------------------------------------------
module farthest_point_selector import fps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                 in_set_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_point_index,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                 out_dropped_overflow,
  output logic                 out_result_last
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_SWEEP,
    ST_PICK
  } state_t;

  state_t                state_r;
  logic [CFG_W-1:0]      max_points_r;
  logic [CNT_W-1:0]      loaded_count_r;
  logic [CNT_W-1:0]      picked_count_r;
  logic [CNT_W-1:0]      issue_cnt_r;
  logic                  overflow_r;
  logic [MAX_CANDIDATES-1:0] picked_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  logic                  out_valid_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_ovf_r, out_last_r;

  // memories
  logic [XY_W-1:0]       xy_mem [MAX_CANDIDATES];
  logic [SQ_W-1:0]       nsq_mem [MAX_CANDIDATES];
  logic [XY_W-1:0]       xy_q_r;
  logic [SQ_W-1:0]       nsq_q_r;

  // sweep pipeline
  logic                  s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]      s1_idx_r, s2_idx_r, s3_idx_r;
  logic                  s2_skip_r, s3_skip_r;
  logic [COORD_BITS-1:0] s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic [COORD_BITS-1:0] s2_dx_r, s2_dy_r;
  logic [XY_W-1:0]       s3_sqx_r, s3_sqy_r;
  logic [SQ_W-1:0]       s2_nsq_r, s3_nsq_r;

  logic                  found_r;
  logic [SQ_W-1:0]       best_v_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [COORD_BITS-1:0] best_x_r, best_y_r;

  logic                  in_xfer, out_free, load_ok;
  logic [CNT_W-1:0]      n_nxt;
  logic [CFG_W-1:0]      limit;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  issue;
  logic                  sweep_start;
  logic                  sweep_done;
  logic                  use_max;
  logic [COORD_BITS-1:0] xq, yq;
  logic [SQ_W-1:0]       s4_d, s4_old, s4_new;
  logic                  s4_act;

  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_ok  = (loaded_count_r < CNT_W'(MAX_CANDIDATES));
  assign n_nxt    = load_ok ? loaded_count_r + CNT_W'(1) : loaded_count_r;

  // clamp the configured limit to 1..RESULT_CAP
  always_comb begin
    if (max_points_r == '0) begin
      limit = CFG_W'(1);
    end else if (max_points_r > CFG_W'(RESULT_CAP)) begin
      limit = CFG_W'(RESULT_CAP);
    end else begin
      limit = max_points_r;
    end
  end

  // issue one read per cycle during a sweep; single read in emit
  assign issue      = (state_r == ST_SWEEP) && (issue_cnt_r < loaded_count_r);
  assign rd_en      = issue || (state_r == ST_EMIT_RD);
  assign rd_addr    = issue_cnt_r[IDX_W-1:0];
  assign sweep_done = (state_r == ST_SWEEP) && !issue && !s1_v_r && !s2_v_r && !s3_v_r;
  assign use_max    = (picked_count_r <= CNT_W'(1));
  assign xq         = xy_q_r[XY_W-1:COORD_BITS];
  assign yq         = xy_q_r[COORD_BITS-1:0];

  // control FSM, counters, picked mask and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      max_points_r   <= CFG_W'(MAX_POINTS_RST);
      loaded_count_r <= '0;
      picked_count_r <= '0;
      issue_cnt_r    <= '0;
      overflow_r     <= 1'b0;
      picked_r       <= '0;
      out_valid_r    <= 1'b0;
      sweep_start    <= 1'b0;
      px_r           <= '0;
      py_r           <= '0;
    end else begin
      sweep_start <= 1'b0;
      if (cfg_we) begin
        max_points_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            loaded_count_r <= n_nxt;
            if (!load_ok) begin
              overflow_r <= 1'b1;
            end
            if (in_set_last) begin
              issue_cnt_r    <= '0;
              picked_count_r <= '0;
              if (n_nxt <= limit) begin
                state_r <= ST_EMIT_RD;
              end else begin
                px_r        <= '0;
                py_r        <= '0;
                sweep_start <= 1'b1;
                state_r     <= ST_SWEEP;
              end
            end
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_WR;
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= OUT_IDX_W'(issue_cnt_r);
            out_x_r     <= xq;
            out_y_r     <= yq;
            out_ovf_r   <= overflow_r;
            out_last_r  <= (issue_cnt_r + CNT_W'(1) == loaded_count_r);
            if (issue_cnt_r + CNT_W'(1) == loaded_count_r) begin
              loaded_count_r <= '0;
              overflow_r     <= 1'b0;
              state_r        <= ST_LOAD;
            end else begin
              issue_cnt_r <= issue_cnt_r + CNT_W'(1);
              state_r     <= ST_EMIT_RD;
            end
          end
        end
        ST_SWEEP: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
          end
          if (sweep_done) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_idx_r            <= OUT_IDX_W'(best_idx_r);
            out_x_r              <= best_x_r;
            out_y_r              <= best_y_r;
            out_ovf_r            <= overflow_r;
            out_last_r           <= (picked_count_r + CNT_W'(1) == CNT_W'(limit));
            picked_r[best_idx_r] <= 1'b1;
            px_r                 <= best_x_r;
            py_r                 <= best_y_r;
            if (picked_count_r + CNT_W'(1) == CNT_W'(limit)) begin
              loaded_count_r <= '0;
              picked_count_r <= '0;
              overflow_r     <= 1'b0;
              picked_r       <= '0;
              state_r        <= ST_LOAD;
            end else begin
              picked_count_r <= picked_count_r + CNT_W'(1);
              issue_cnt_r    <= '0;
              sweep_start    <= 1'b1;
              state_r        <= ST_SWEEP;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // point memory: write on load, registered read
  always_ff @(posedge clk) begin
    if (in_xfer && load_ok) begin
      xy_mem[loaded_count_r[IDX_W-1:0]] <= {in_point_x, in_point_y};
    end
    if (rd_en) begin
      xy_q_r <= xy_mem[rd_addr];
    end
  end

  // stage 4: nearest distance update and running maximum
  assign s4_d   = SQ_W'(s3_sqx_r) + SQ_W'(s3_sqy_r);
  assign s4_old = use_max ? {SQ_W{1'b1}} : s3_nsq_r;
  assign s4_new = (s4_d < s4_old) ? s4_d : s4_old;
  assign s4_act = s3_v_r && !s3_skip_r;

  // nearest distance memory: written back at stage 4, registered read
  always_ff @(posedge clk) begin
    if (s4_act) begin
      nsq_mem[s3_idx_r] <= s4_new;
    end
    if (rd_en) begin
      nsq_q_r <= nsq_mem[rd_addr];
    end
  end

  // sweep pipeline valids and best tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (sweep_start) begin
        found_r <= 1'b0;
      end else if (s4_act && (!found_r || s4_new > best_v_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  // sweep pipeline payload: absolute differences, squares, best point
  always_ff @(posedge clk) begin
    s1_idx_r  <= rd_addr;
    s2_idx_r  <= s1_idx_r;
    s2_skip_r <= picked_r[s1_idx_r];
    s2_x_r    <= xq;
    s2_y_r    <= yq;
    s2_dx_r   <= (xq >= px_r) ? xq - px_r : px_r - xq;
    s2_dy_r   <= (yq >= py_r) ? yq - py_r : py_r - yq;
    s2_nsq_r  <= nsq_q_r;
    s3_idx_r  <= s2_idx_r;
    s3_skip_r <= s2_skip_r;
    s3_x_r    <= s2_x_r;
    s3_y_r    <= s2_y_r;
    s3_sqx_r  <= s2_dx_r * s2_dx_r;
    s3_sqy_r  <= s2_dy_r * s2_dy_r;
    s3_nsq_r  <= s2_nsq_r;
    if (s4_act && (!found_r || s4_new > best_v_r)) begin
      best_v_r   <= s4_new;
      best_idx_r <= s3_idx_r;
      best_x_r   <= s3_x_r;
      best_y_r   <= s3_y_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_point_index      = out_idx_r;
  assign out_x                = out_x_r;
  assign out_y                = out_y_r;
  assign out_dropped_overflow = out_ovf_r;
  assign out_result_last      = out_last_r;

endmodule

// ===== hdl/fps_checker.sv =====
// ----------------------------------------------------------------------------
// fps_checker - port-level checks for the farthest point selector
// Watches the handshakes and the set sequencing seen at the top level.
// ----------------------------------------------------------------------------
module fps_checker import fps_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [OUT_IDX_W-1:0]  out_point_index,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  out_result_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_point_index) && $stable(out_x) &&
      $stable(out_y) && $stable(out_result_last))
    else $error("stalled result changed");

  // no new result appears while points are being loaded
  a_no_result_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> !$rose(out_valid))
    else $error("result produced during load");

  // loading stays closed until the final result of a set is issued
  a_stall_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |-> in_stall)
    else $error("input opened before set finished");

endmodule

bind farthest_point_selector fps_checker u_fps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_point_index (out_point_index),
  .out_x           (out_x),
  .out_y           (out_y),
  .out_result_last (out_result_last)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - farthest_point_selector verification
// Streams 2-D point sets through the selector under random idling on both
// channels and scores every emitted point against a farthest-point predictor
// kept inside the bench, across several max_points settings.
// ----------------------------------------------------------------------------
module testbench;
  import fps_pkg::*;

  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned SETTLE_CYC   = 16;
  localparam int unsigned RANDOM_ITEMS = 230;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_REPEAT, SPREAD_EDGE} spread_t;

  typedef struct {
    logic [OUT_IDX_W-1:0]  point_index;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  dropped_overflow;
    logic                  result_last;
  } pick_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_point_x = '0;
  logic [COORD_BITS-1:0] in_point_y = '0;
  logic                  in_set_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]  out_point_index;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_dropped_overflow;
  logic                  out_result_last;

  // no idling on either side while set
  logic                  quiet = 1'b0;
  int unsigned           cycle_count = 0;
  int unsigned           error_count = 0;

  // predictor state: the point set under load and the current limit
  logic [COORD_BITS-1:0] set_x [MAX_CANDIDATES];
  logic [COORD_BITS-1:0] set_y [MAX_CANDIDATES];
  logic [SQ_W-1:0]       nearest_sq [MAX_CANDIDATES];
  bit                    taken [MAX_CANDIDATES];
  int unsigned           set_count = 0;
  bit                    set_overflow = 1'b0;
  logic [CFG_W-1:0]      limit_reg = CFG_W'(MAX_POINTS_RST);
  pick_t                 expected_picks[$];

  farthest_point_selector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_set_last          (in_set_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_point_index      (out_point_index),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_dropped_overflow (out_dropped_overflow),
    .out_result_last      (out_result_last)
  );

  always #4 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("farthest_point_selector test failed");
      $finish;
    end
  end

  // throttle the result channel
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // exact squared distance, wide enough for any pair of coordinates
  function automatic logic [SQ_W-1:0] sq_span(logic [COORD_BITS-1:0] ax, ay, bx, by);
    logic [COORD_BITS-1:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
  endfunction

  function automatic void record_pick(int unsigned idx, bit last);
    pick_t p;
    p.point_index      = OUT_IDX_W'(idx);
    p.x                = set_x[idx];
    p.y                = set_y[idx];
    p.dropped_overflow = set_overflow;
    p.result_last      = last;
    expected_picks     = {expected_picks, p};
  endfunction

  // mark a point picked, shrink the nearest distances and queue its result
  function automatic void take_point(int unsigned idx, bit last);
    logic [SQ_W-1:0] d;
    taken[idx] = 1'b1;
    for (int unsigned i = 0; i < set_count; i++) begin
      if (!taken[i]) begin
        d = sq_span(set_x[i], set_y[i], set_x[idx], set_y[idx]);
        if (d < nearest_sq[i]) nearest_sq[i] = d;
      end
    end
    record_pick(idx, last);
  endfunction

  // load one point; on set_last work out the whole emitted sequence
  function automatic void predict_point(logic [COORD_BITS-1:0] x, y, logic last);
    int unsigned     lim, best;
    logic [SQ_W-1:0] best_v, v;
    bit              found;
    if (set_count < MAX_CANDIDATES) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return;

    lim = (limit_reg == 0) ? 1 : (limit_reg > RESULT_CAP) ? RESULT_CAP : limit_reg;
    if (set_count <= lim) begin
      for (int unsigned k = 0; k < set_count; k++) record_pick(k, k + 1 == set_count);
    end else begin
      for (int unsigned i = 0; i < set_count; i++) nearest_sq[i] = '1;
      // first pick: largest squared norm, earliest on a tie
      best   = 0;
      best_v = '0;
      for (int unsigned i = 0; i < set_count; i++) begin
        v = sq_span(set_x[i], set_y[i], '0, '0);
        if (i == 0 || v > best_v) begin
          best_v = v;
          best   = i;
        end
      end
      take_point(best, lim == 1);
      // later picks: farthest from the picked set, earliest on a tie
      for (int unsigned k = 1; k < lim; k++) begin
        found  = 1'b0;
        best   = 0;
        best_v = '0;
        for (int unsigned i = 0; i < set_count; i++) begin
          if (!taken[i] && (!found || nearest_sq[i] > best_v)) begin
            found  = 1'b1;
            best_v = nearest_sq[i];
            best   = i;
          end
        end
        take_point(best, k + 1 == lim);
      end
    end
    taken        = '{default: 1'b0};
    set_count    = 0;
    set_overflow = 1'b0;
  endfunction

  // score each result transfer against the oldest expected pick
  always @(posedge clk) begin : check_result
    pick_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        $error("result with no expected pick: point_index %0d", out_point_index);
        error_count++;
      end else begin
        p = expected_picks.pop_front();
        if (out_point_index !== p.point_index) begin
          $error("point_index: expected %0d, got %0d", p.point_index, out_point_index);
          error_count++;
        end
        if (out_x !== p.x) begin
          $error("out_x: expected %0h, got %0h", p.x, out_x);
          error_count++;
        end
        if (out_y !== p.y) begin
          $error("out_y: expected %0h, got %0h", p.y, out_y);
          error_count++;
        end
        if (out_dropped_overflow !== p.dropped_overflow) begin
          $error("dropped_overflow: expected %0b, got %0b",
                 p.dropped_overflow, out_dropped_overflow);
          error_count++;
        end
        if (out_result_last !== p.result_last) begin
          $error("result_last: expected %0b, got %0b", p.result_last, out_result_last);
          error_count++;
        end
      end
    end
  end

  // offer one point, hold it until the transfer, then update the predictor
  task automatic transfer_point(input logic [COORD_BITS-1:0] x, y, input logic last);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_point_x  <= x;
    in_point_y  <= y;
    in_set_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_point(x, y, last);
  endtask

  // drop valid, drain all expected picks and let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  function automatic logic [COORD_BITS-1:0] boundary_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return {1'b0, {(COORD_BITS-1){1'b1}}};
    endcase
  endfunction

  // send one complete set of n points drawn with the given spread
  task automatic send_set(input int unsigned n, input spread_t spread);
    logic [COORD_BITS-1:0] xs [128];
    logic [COORD_BITS-1:0] ys [128];
    int unsigned           r;
    for (int unsigned j = 0; j < n; j++) begin
      case (spread)
        SPREAD_TIGHT: begin
          xs[j] = COORD_BITS'($urandom_range(0, 7));
          ys[j] = COORD_BITS'($urandom_range(0, 7));
        end
        SPREAD_REPEAT: begin
          if (j > 0 && $urandom_range(0, 1)) begin
            r     = $urandom_range(0, j - 1);
            xs[j] = xs[r];
            ys[j] = ys[r];
          end else begin
            xs[j] = COORD_BITS'($urandom);
            ys[j] = COORD_BITS'($urandom);
          end
        end
        SPREAD_EDGE: begin
          xs[j] = boundary_coord();
          ys[j] = boundary_coord();
        end
        default: begin
          xs[j] = COORD_BITS'($urandom);
          ys[j] = COORD_BITS'($urandom);
        end
      endcase
      transfer_point(xs[j], ys[j], j + 1 == n);
    end
  endtask

  // reset limit of 16: single-point set and a small set passed through in order
  task automatic test_default_limit();
    transfer_point('0, '0, 1'b1);
    transfer_point('1, '1, 1'b0);
    transfer_point('0, '0, 1'b0);
    transfer_point(16'h8000, 16'h7FFF, 1'b1);
  endtask

  // one pick per set: equal norms go to the earliest point; zero acts as one
  task automatic test_single_pick();
    write_limit(CFG_W'(1));
    transfer_point(16'd3, 16'd4, 1'b0);
    transfer_point(16'd0, 16'd5, 1'b0);
    transfer_point(16'd4, 16'd3, 1'b0);
    transfer_point(16'd1, 16'd1, 1'b1);
    write_limit('0);
    transfer_point('0, '0, 1'b0);
    transfer_point('1, '0, 1'b0);
    transfer_point('0, '1, 1'b1);
  endtask

  // farthest-point order, duplicates and all-equal distances
  task automatic test_farthest_ties();
    write_limit(CFG_W'(3));
    transfer_point(16'd100, 16'd100, 1'b0);
    transfer_point(16'd100, 16'd100, 1'b0);
    transfer_point(16'd0, 16'd0, 1'b0);
    transfer_point(16'd200, 16'd200, 1'b0);
    transfer_point(16'd200, 16'd0, 1'b1);
    for (int unsigned j = 0; j < 4; j++) transfer_point(16'd5, 16'd5, j == 3);
  endtask

  // limit above the cap saturates, so a small set passes whole
  task automatic test_limit_saturate();
    write_limit('1);
    send_set(5, SPREAD_EDGE);
  endtask

  // sets at and past the store depth: dropped points flagged, set_last on a dropped point
  task automatic test_store_overflow();
    write_limit(CFG_W'(RESULT_CAP));
    send_set(MAX_CANDIDATES + 1, SPREAD_FULL);
    write_limit(CFG_W'(RESULT_CAP - 1));
    send_set(MAX_CANDIDATES + 4, SPREAD_FULL);
    write_limit('1);
    send_set(MAX_CANDIDATES, SPREAD_TIGHT);
  endtask

  // random sets under changing limits, with one stretch free of idling
  task automatic test_random_sets();
    int unsigned sent, sets, n;
    sent = 0;
    sets = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sets % 4 == 0) begin
        case ($urandom_range(0, 5))
          0:       write_limit('0);
          1:       write_limit(CFG_W'(1));
          2:       write_limit(CFG_W'(RESULT_CAP));
          3:       write_limit('1);
          4:       write_limit(CFG_W'($urandom_range(2, 12)));
          default: write_limit(CFG_W'($urandom_range(0, 127)));
        endcase
      end
      quiet <= (sets >= 4 && sets < 10);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 72) : $urandom_range(1, 20);
      send_set(n, spread_t'($urandom_range(0, 3)));
      sent += n;
      sets++;
    end
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limit();
    test_single_pick();
    test_farthest_ties();
    test_limit_saturate();
    test_store_overflow();
    test_random_sets();
    wait_idle();
    if (error_count == 0 && expected_picks.size() == 0) begin
      $display("farthest_point_selector test passed");
    end else begin
      $display("farthest_point_selector test failed");
    end
    $finish;
  end

endmodule
